// ===== sv/fmsr_pkg.sv =====
// Package for the first-match search and replace core.
// Holds byte and result-buffer widths and the configuration register indexes.
// No dependencies.
package fmsr_pkg;

    localparam int BYTE_W    = 8;
    localparam int REPL_MAX  = 8;   // replacement bytes held in the register
    localparam int RES_CNT_W = 4;   // holds 0..REPL_MAX
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

endpackage

// ===== sv/first_match_search_replace_core.sv =====
// Top level of the first-match search and replace core: input register, window
// logic and a shifting result buffer. Depends on fmsr_pkg.
//
//  channel | signals                                    | direction | handshake
//  --------+--------------------------------------------+-----------+-----------
//  text in | in_valid, in_ready, text_byte, text_end     | in        | valid/ready
//  result  | out_valid, out_ready, out_byte, has_byte,   | out       | valid/ready
//          | last, found                                 |           |
//  config  | cfg_we, cfg_index, cfg_data                 | in        | write only
//
// An item is worked out combinationally, input register to result buffer.
// Items with at most one result stream at one per cycle while out_ready is high; an
// item with n results holds the buffer until all n have drained, one per transfer.
// The input register takes one further item while the buffer drains. rst_n clears the
// window fill, replaced flag, valid flags and configuration; pattern length set to 1.
module first_match_search_replace_core
    import fmsr_pkg::*;
#(
    parameter int PATTERN_MAX = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic                 text_end,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 has_byte,
    output logic                 last,
    output logic                 found,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int FW = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_W-1:0] PLEN_CAP = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] RLEN_CAP = LEN_W'(REPL_MAX);

    // configuration
    logic [CFG_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] replacement_bytes_reg;
    logic [LEN_W-1:0] replacement_length_reg;

    // input register
    logic   in_valid_reg;
    byte_t  in_byte_reg;
    logic   in_end_reg;

    // window state
    byte_t   win_reg [PATTERN_MAX];
    byte_t   win_ins [PATTERN_MAX];
    byte_t   win_next [PATTERN_MAX];
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] fill_ins;
    logic          replaced_reg;
    logic          replaced_next;

    // result buffer
    byte_t                res_byte_reg [REPL_MAX];
    byte_t                res_byte_next [REPL_MAX];
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic [RES_CNT_W-1:0] res_cnt_next;
    logic                 res_end_reg;
    logic                 res_found_reg;
    logic                 res_found_next;
    logic                 res_marker_reg;
    logic                 res_marker_next;

    logic [FW-1:0]        plen;
    logic [LEN_W-1:0]     rlen;
    logic                 match;
    logic                 take_repl;
    logic [1:0]           shift;
    logic [RES_CNT_W-1:0] emit_cnt;
    logic                 load;
    logic                 out_xfer;

    assign out_xfer = out_valid && out_ready;
    assign load     = in_valid_reg &&
                      ((res_cnt_reg == '0) || ((res_cnt_reg == RES_CNT_W'(1)) && out_ready));
    assign in_ready = !in_valid_reg || load;

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            plen = FW'(1);
        end
        else if (pattern_length_reg > PLEN_CAP)
        begin
            plen = FW'(PATTERN_MAX);
        end
        else
        begin
            plen = pattern_length_reg[FW-1:0];
        end

        rlen = (replacement_length_reg > RLEN_CAP) ? RLEN_CAP : replacement_length_reg;

        fill_ins = fill_reg + FW'(1);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            win_ins[i] = (FW'(i) == fill_reg) ? in_byte_reg : win_reg[i];
        end

        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((FW'(i) < plen) && (win_ins[i] != pattern_bytes_reg[BYTE_W*i +: BYTE_W]))
            begin
                match = 1'b0;
            end
        end

        take_repl     = 1'b0;
        shift         = 2'd0;
        fill_next     = fill_ins;
        replaced_next = replaced_reg;
        priority if (fill_ins > plen)
        begin
            // window longer than pattern: drain two, or all at text end
            shift     = 2'd2;
            fill_next = fill_ins - FW'(2);
            emit_cnt  = in_end_reg ? RES_CNT_W'(fill_ins) : RES_CNT_W'(2);
        end
        else if (fill_ins == plen)
        begin
            if (!replaced_reg && match)
            begin
                take_repl     = 1'b1;
                fill_next     = '0;
                replaced_next = 1'b1;
                emit_cnt      = RES_CNT_W'(rlen);
            end
            else
            begin
                shift     = 2'd1;
                fill_next = fill_ins - FW'(1);
                emit_cnt  = in_end_reg ? RES_CNT_W'(fill_ins) : RES_CNT_W'(1);
            end
        end
        else
        begin
            emit_cnt = in_end_reg ? RES_CNT_W'(fill_ins) : '0;
        end

        res_found_next = replaced_next;
        if (in_end_reg)
        begin
            fill_next     = '0;
            replaced_next = 1'b0;
        end

        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            unique case (shift)
                2'd1:    win_next[i] = (i + 1 < PATTERN_MAX) ? win_ins[(i + 1) % PATTERN_MAX]
                                                             : win_ins[i];
                2'd2:    win_next[i] = (i + 2 < PATTERN_MAX) ? win_ins[(i + 2) % PATTERN_MAX]
                                                             : win_ins[i];
                default: win_next[i] = win_ins[i];
            endcase
        end

        // replacement bytes, or the window prefix when draining
        for (int j = 0; j < REPL_MAX; j++)
        begin
            if (take_repl)
            begin
                res_byte_next[j] = replacement_bytes_reg[BYTE_W*j +: BYTE_W];
            end
            else if (j < PATTERN_MAX)
            begin
                res_byte_next[j] = win_ins[j % PATTERN_MAX];
            end
            else
            begin
                res_byte_next[j] = '0;
            end
        end

        // end of text with nothing to emit: one empty marker
        res_marker_next = in_end_reg && (emit_cnt == '0);
        res_cnt_next    = res_marker_next ? RES_CNT_W'(1) : emit_cnt;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data;
                CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // input register and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            fill_reg     <= '0;
            replaced_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (load)
            begin
                fill_reg     <= fill_next;
                replaced_reg <= replaced_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= text_byte;
            in_end_reg  <= text_end;
        end
        if (load)
        begin
            win_reg <= win_next;
        end
    end

    // result buffer: loaded whole, drained from entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= '0;
        end
        else if (load)
        begin
            res_cnt_reg <= res_cnt_next;
        end
        else if (out_xfer)
        begin
            res_cnt_reg <= res_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_byte_reg   <= res_byte_next;
            res_end_reg    <= in_end_reg;
            res_found_reg  <= res_found_next;
            res_marker_reg <= res_marker_next;
        end
        else if (out_xfer)
        begin
            for (int j = 0; j < REPL_MAX - 1; j++)
            begin
                res_byte_reg[j] <= res_byte_reg[j + 1];
            end
        end
    end

    assign out_valid = (res_cnt_reg != '0);
    assign has_byte  = !res_marker_reg;
    assign out_byte  = res_marker_reg ? '0 : res_byte_reg[0];
    assign last      = res_end_reg && (res_cnt_reg == RES_CNT_W'(1));
    assign found     = last && res_found_reg;

    // checks
    a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(REPL_MAX))
        else $error("result count above buffer depth");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FW'(PATTERN_MAX))
        else $error("window fill reached pattern capacity");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_end_reg |=> (fill_reg == '0) && !replaced_reg)
        else $error("text end did not clear window state");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last)
        else $error("empty marker not on final result");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !load |=> in_valid_reg)
        else $error("pending item dropped from input register");

endmodule

// ===== dv/first_match_search_replace_core_test.sv =====
// Self-checking testbench for first_match_search_replace_core.
// Holds its own copy of the text window, predicts every result and checks
// all transfers on the result channel. Depends on fmsr_pkg and the core.
`timescale 1ns / 100ps

module first_match_search_replace_core_test;
    import fmsr_pkg::*;

    localparam int PAT_MAX   = 8;
    localparam int STUCK_MAX = 4000;
    localparam int SHOW_MAX  = 10;

    typedef struct packed {
        byte_t value;
        logic  is_end;
    } text_item_t;

    typedef struct packed {
        byte_t data;
        logic  has_data;
        logic  is_last;
        logic  found_flag;
    } out_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    text_byte = '0;
    logic                 text_end = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 has_byte;
    logic                 last;
    logic                 found;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Shadow of the configuration registers
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len = 4'd0;

    // Shadow of the window state
    byte_t hold_bytes [8];
    int    hold_count = 0;
    logic  swap_done = 1'b0;

    text_item_t text_q [$];
    out_item_t  out_bytes_due [$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic in_taken = 1'b0;
    logic drain_hold = 1'b0;
    int   stuck_cycles = 0;
    int   bad_count = 0;
    text_item_t next_item;

    first_match_search_replace_core #(
        .PATTERN_MAX(PAT_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .text_byte(text_byte),
        .text_end (text_end),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte (out_byte),
        .has_byte (has_byte),
        .last     (last),
        .found    (found),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic byte_t take_oldest();
        byte_t b;
        b = hold_bytes[0];
        for (int i = 1; i < 8; i++)
            hold_bytes[i-1] = hold_bytes[i];
        if (hold_count > 0)
            hold_count--;
        return b;
    endfunction

    function automatic void push_due(byte_t b, logic has);
        out_item_t r;
        r.data = b;
        r.has_data = has;
        r.is_last = 1'b0;
        r.found_flag = 1'b0;
        out_bytes_due.push_back(r);
    endfunction

    function automatic int eff_pat_len(logic [3:0] raw);
        if (raw == 0)
            return 1;
        if (raw > PAT_MAX)
            return PAT_MAX;
        return int'(raw);
    endfunction

    // One accepted text byte: works out the results it causes
    function automatic void search_replace_step(byte_t b, logic e);
        int   plen;
        int   rlen;
        int   k;
        int   idx;
        logic hit;
        plen = eff_pat_len(pat_len);
        k = 0;
        if (hold_count > 7)
            hold_count = 7;
        hold_bytes[hold_count] = b;
        hold_count++;
        if (hold_count > plen)
        begin
            // window longer than the pattern: no match test, drain two
            push_due(take_oldest(), 1'b1);
            push_due(take_oldest(), 1'b1);
            k = 2;
        end
        else if (hold_count == plen)
        begin
            hit = !swap_done;
            for (int i = 0; i < plen; i++)
                if (hold_bytes[i] != pat_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                rlen = (rep_len > 8) ? 8 : int'(rep_len);
                for (int i = 0; i < rlen; i++)
                    push_due(rep_bytes[8*i +: 8], 1'b1);
                k = rlen;
                hold_count = 0;
                swap_done = 1'b1;
            end
            else
            begin
                push_due(take_oldest(), 1'b1);
                k = 1;
            end
        end
        if (e)
        begin
            while (hold_count > 0 && k < 8)
            begin
                push_due(take_oldest(), 1'b1);
                k++;
            end
            if (k == 0)
            begin
                push_due(8'h00, 1'b0);
                k = 1;
            end
            idx = out_bytes_due.size() - 1;
            out_bytes_due[idx].is_last = 1'b1;
            out_bytes_due[idx].found_flag = swap_done;
            hold_count = 0;
            swap_done = 1'b0;
        end
    endfunction

    function automatic void note_fail(string msg);
        bad_count++;
        if (bad_count <= SHOW_MAX)
            $display("%s", msg);
    endfunction

    // Sender: new payload at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (drain_hold && out_bytes_due.size() == 0)
                drain_hold = 1'b0;
            if (!drain_hold && text_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = text_q.pop_front();
                text_byte <= next_item.value;
                text_end <= next_item.is_end;
                in_valid <= 1'b1;
                // now and then hold off until everything due has drained
                if ($urandom_range(59) == 0)
                    drain_hold = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: checks result transfers, feeds the predictor, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (out_bytes_due.size() == 0)
                    note_fail($sformatf("unexpected result: byte %02h has %0b last %0b found %0b",
                                        out_byte, has_byte, last, found));
                else
                begin
                    if (out_bytes_due[0] != {out_byte, has_byte, last, found})
                        note_fail($sformatf(
                            "mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                            out_bytes_due[0].data, out_bytes_due[0].has_data,
                            out_bytes_due[0].is_last, out_bytes_due[0].found_flag,
                            out_byte, has_byte, last, found));
                    void'(out_bytes_due.pop_front());
                end
            end
            if (in_valid && in_ready)
                search_replace_step(text_byte, text_end);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_MAX)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic add_item(byte_t b, logic e);
        text_item_t it;
        it.value = b;
        it.is_end = e;
        text_q.push_back(it);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_PATTERN_BYTES:      pat_bytes = v;
            CFG_PATTERN_LENGTH:     pat_len = v[3:0];
            CFG_REPLACEMENT_BYTES:  rep_bytes = v;
            CFG_REPLACEMENT_LENGTH: rep_len = v[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Everything sent and every result in, then room for a silent item
    task automatic wait_drained();
        do
            @(posedge clk);
        while (text_q.size() != 0 || in_valid || out_bytes_due.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        byte_t       alpha [3];
        byte_t       txt [12];
        logic [63:0] pb;
        logic [3:0]  plen_raw;
        logic [3:0]  rlen_raw;
        int          plen;
        int          items;
        int          n;
        int          pos;
        int          r;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int sub = 0; sub < 2; sub++)
        begin
            for (int i = 0; i < 3; i++)
                alpha[i] = $urandom_range(255);
            r = $urandom_range(9);
            plen_raw = (r == 9) ? 4'($urandom_range(15, 9)) : 4'(r);
            plen = eff_pat_len(plen_raw);
            pb = {$urandom, $urandom};
            for (int i = 0; i < plen; i++)
                pb[8*i +: 8] = alpha[$urandom_range(2)];
            r = $urandom_range(10);
            rlen_raw = (r > 8) ? 4'($urandom_range(15, 9)) : 4'(r);
            write_reg(CFG_PATTERN_BYTES, pb);
            write_reg(CFG_PATTERN_LENGTH, {60'd0, plen_raw});
            write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
            write_reg(CFG_REPLACEMENT_LENGTH, {60'd0, rlen_raw});
            items = 0;
            while (items < 20)
            begin
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++)
                    txt[i] = ($urandom_range(99) < 80) ? alpha[$urandom_range(2)]
                                                       : byte_t'($urandom_range(255));
                // most texts carry the pattern somewhere
                if ($urandom_range(99) < 70 && n >= plen)
                begin
                    pos = $urandom_range(n - plen);
                    for (int i = 0; i < plen; i++)
                        txt[pos + i] = pb[8*i +: 8];
                end
                for (int i = 0; i < n; i++)
                    add_item(txt[i], i == n - 1);
                items += n;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        foreach (hold_bytes[i])
            hold_bytes[i] = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: single zero byte pattern, empty replacement
        add_item(8'h00, 1'b1);
        add_item(8'hff, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h00, 1'b1);
        wait_drained();

        // Out-of-range lengths clamp to eight
        write_reg(CFG_PATTERN_BYTES, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_PATTERN_LENGTH, 64'd15);
        write_reg(CFG_REPLACEMENT_BYTES, 64'h0123_4567_89ab_cdef);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'd15);
        repeat (7) add_item(8'hff, 1'b0);
        add_item(8'hff, 1'b1);
        add_item(8'h80, 1'b0);
        add_item(8'h7f, 1'b0);
        add_item(8'hff, 1'b1);
        wait_drained();

        // Pattern shortened mid-text, zero length taken as one
        write_reg(CFG_PATTERN_BYTES, 64'h6463_6261);
        write_reg(CFG_PATTERN_LENGTH, 64'd4);
        write_reg(CFG_REPLACEMENT_BYTES, 64'h7978);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'd2);
        add_item(8'h71, 1'b0);
        add_item(8'h72, 1'b0);
        add_item(8'h73, 1'b0);
        wait_drained();
        write_reg(CFG_PATTERN_LENGTH, 64'd0);
        add_item(8'h61, 1'b0);
        add_item(8'h61, 1'b0);
        add_item(8'h62, 1'b1);
        add_item(8'h7a, 1'b0);
        add_item(8'h61, 1'b1);
        wait_drained();

        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(31, 31);

        wait_drained();
        repeat (20) @(posedge clk);
        if (bad_count == 0 && out_bytes_due.size() == 0)
            $display("tb: success");
        else
        begin
            if (out_bytes_due.size() != 0)
                $display("%0d results never arrived", out_bytes_due.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
